// ===== rtl/core/rdc_pkg.sv =====
// shared constants and types for the repeating decimal cycle finder
package rdc_pkg;

  localparam int MAX_DEN   = 64;
  localparam int MAX_STEPS = 64;

  localparam int NUM_W  = 6;
  localparam int DEN_W  = 7;
  localparam int REM_W  = $clog2(MAX_DEN);
  localparam int CNT_W  = $clog2(MAX_STEPS) + 1;
  localparam int POS_W  = $clog2(MAX_STEPS);
  localparam int DIG_W  = 4;
  localparam int LEN_W  = 6;
  localparam int DIVD_W = 10;
  localparam int QUO_W  = 4;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quot;
    logic [REM_W-1:0]  rem;
  } div_res_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

endpackage

// ===== rtl/core/rdc_div.sv =====
// restoring divider, one quotient bit per cycle, for a single decimal digit
module rdc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [rdc_pkg::DIVD_W-1:0] dividend,
  input  logic [rdc_pkg::DEN_W-1:0]  divisor,
  output rdc_pkg::div_res_t         res
);
  import rdc_pkg::*;

  localparam int STEP_W = $clog2(QUO_W);

  logic              run;
  logic [STEP_W-1:0] k;
  logic [DIVD_W-1:0] part;
  logic [DEN_W-1:0]  dvs;
  logic [QUO_W-1:0]  q;

  logic [DIVD_W-1:0] shifted;
  logic              ge;
  logic [DIVD_W-1:0] part_next;
  logic [QUO_W-1:0]  q_next;

  always_comb begin
    shifted   = DIVD_W'(dvs) << k;
    ge        = part >= shifted;
    part_next = ge ? part - shifted : part;
    q_next    = q | (QUO_W'(ge) << k);
  end

  assign res.done = run && (k == '0);
  assign res.quot = q_next;
  assign res.rem  = part_next[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (load) begin
      run <= 1'b1;
    end else if (res.done) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      part <= dividend;
      dvs  <= divisor;
      q    <= '0;
      k    <= STEP_W'(QUO_W - 1);
    end else if (run) begin
      part <= part_next;
      q    <= q_next;
      k    <= k - STEP_W'(1);
    end
  end

endmodule

// ===== rtl/core/repeating_decimal_cycle.sv =====
// repeating decimal cycle finder: long division with a remainder position table
// a rejected fraction gives its result in the cycle after start; otherwise each digit
// produced takes one table check and one divider run, and once a remainder repeats
// the cycle digits follow one per cycle
// busy is high through division and digit output; results cannot be stalled
// rst is synchronous and returns the sequencer to idle with no result pending
module repeating_decimal_cycle (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [rdc_pkg::NUM_W-1:0]  numerator,
  input  logic [rdc_pkg::DEN_W-1:0]  denominator,
  output logic                       result_valid,
  output logic [rdc_pkg::DIG_W-1:0]  cycle_digit,
  output logic [rdc_pkg::LEN_W-1:0]  cycle_length,
  output logic                       no_cycle,
  output logic                       bad_input,
  output logic                       last
);
  import rdc_pkg::*;

  state_t            state;
  logic [REM_W-1:0]  r;
  logic [DEN_W-1:0]  den;
  logic [CNT_W-1:0]  count;
  logic [MAX_DEN-1:0] seen_vld;
  logic [POS_W-1:0]  seen_mem [MAX_DEN];
  logic [POS_W-1:0]  seen_q;
  logic [DIG_W-1:0]  digit_mem [MAX_STEPS];
  logic [DIG_W-1:0]  digit_q;
  logic [LEN_W-1:0]  cyc_len;
  logic [LEN_W-1:0]  emit_cnt;
  logic [POS_W-1:0]  emit_ptr;
  logic              res_valid;
  logic              res_no_cycle;
  logic              res_bad;

  logic              accept;
  logic              frac_bad;
  logic              div_load;
  logic [DIVD_W-1:0] r_times_ten;
  div_res_t          div_res;
  logic              seen_we;
  logic [REM_W-1:0]  seen_raddr;
  logic [POS_W-1:0]  digit_raddr;
  logic              emitting;
  logic              emit_last;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign frac_bad = (denominator == '0) || (DEN_W'(numerator) >= denominator) ||
                    (denominator > DEN_W'(MAX_DEN));

  // r*10 as shift and add
  assign r_times_ten = (DIVD_W'(r) << 3) + (DIVD_W'(r) << 1);
  assign div_load    = (state == S_CHECK) && (r != '0) && !seen_vld[r] &&
                       (count < CNT_W'(MAX_STEPS));

  rdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend (r_times_ten),
    .divisor  (den),
    .res      (div_res)
  );

  assign seen_we     = (state == S_DIV) && div_res.done;
  assign seen_raddr  = (state == S_IDLE) ? REM_W'(numerator) : div_res.rem;
  assign digit_raddr = (state == S_CHECK) ? seen_q : emit_ptr + POS_W'(1);

  // remainder position table, write-through when the new remainder equals the old
  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[r] <= count[POS_W-1:0];
    end
    if (seen_we && (seen_raddr == r)) begin
      seen_q <= count[POS_W-1:0];
    end else begin
      seen_q <= seen_mem[seen_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      digit_mem[count[POS_W-1:0]] <= div_res.quot;
    end
    digit_q <= digit_mem[digit_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seen_vld  <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (frac_bad) begin
              res_valid    <= 1'b1;
              res_bad      <= 1'b1;
              res_no_cycle <= 1'b0;
            end else begin
              seen_vld <= '0;
              r        <= REM_W'(numerator);
              den      <= denominator;
              count    <= '0;
              state    <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (r == '0) begin
            res_valid    <= 1'b1;
            res_no_cycle <= 1'b1;
            res_bad      <= 1'b0;
            state        <= S_IDLE;
          end else if (seen_vld[r]) begin
            cyc_len  <= LEN_W'(count - CNT_W'(seen_q));
            emit_ptr <= seen_q;
            emit_cnt <= '0;
            state    <= S_EMIT;
          end else if (!div_load) begin
            // step limit reached without a repeat
            res_valid    <= 1'b1;
            res_bad      <= 1'b1;
            res_no_cycle <= 1'b0;
            state        <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            seen_vld[r] <= 1'b1;
            r           <= div_res.rem;
            count       <= count + CNT_W'(1);
            state       <= S_CHECK;
          end
        end
        S_EMIT: begin
          emit_ptr <= emit_ptr + POS_W'(1);
          emit_cnt <= emit_cnt + LEN_W'(1);
          if (emit_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign emitting  = (state == S_EMIT);
  assign emit_last = (emit_cnt == cyc_len - LEN_W'(1));

  assign result_valid = res_valid || emitting;
  assign cycle_digit  = emitting ? digit_q : '0;
  assign cycle_length = emitting ? cyc_len : '0;
  assign no_cycle     = !emitting && res_no_cycle && res_valid;
  assign bad_input    = !emitting && res_bad && res_valid;
  assign last         = emitting ? emit_last : res_valid;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(no_cycle && bad_input))
    else $error("no_cycle and bad_input both set");

  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    (emitting && emit_last) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after last digit");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !bad_input && !no_cycle) |-> (cycle_digit <= DIG_W'(9)))
    else $error("cycle digit out of decimal range");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (count <= CNT_W'(MAX_STEPS)))
    else $error("digit count past step limit");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

endmodule
